// ===== src/u8hist_pkg.sv =====
// ============================================================================
// u8hist_pkg
// shared types and constants of the utf-8 code point histogram unit
// ============================================================================
package u8hist_pkg;

    // field widths fixed by the item format
    localparam int BYTE_WIDTH         = 8;
    localparam int CP_WIDTH           = 21;
    localparam int PEND_WIDTH         = 2;
    localparam int RESULT_COUNT_WIDTH = 32;

    // parameter defaults
    localparam int MAX_CODE_POINT_DEF = 1114111;
    localparam int COUNT_WIDTH_DEF    = 32;

    // payload masks of the byte classes
    localparam logic [BYTE_WIDTH-1:0] LEAD2_MASK = 8'h1F;
    localparam logic [BYTE_WIDTH-1:0] LEAD3_MASK = 8'h0F;
    localparam logic [BYTE_WIDTH-1:0] LEAD4_MASK = 8'h07;
    localparam logic [BYTE_WIDTH-1:0] CONT_MASK  = 8'h3F;
    localparam int                    CONT_BITS  = 6;

    // continuations expected after each lead byte
    localparam logic [PEND_WIDTH-1:0] PEND_NONE  = 2'd0;
    localparam logic [PEND_WIDTH-1:0] PEND_LEAD2 = 2'd1;
    localparam logic [PEND_WIDTH-1:0] PEND_LEAD3 = 2'd2;
    localparam logic [PEND_WIDTH-1:0] PEND_LEAD4 = 2'd3;

    // transaction modes
    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_READ = 1'b1;

    typedef enum logic [2:0] {
        ST_ACCEPTED     = 3'd0,
        ST_LINE_VALID   = 3'd1,
        ST_LINE_INVALID = 3'd2,
        ST_DISCARDED    = 3'd3,
        ST_READ_DONE    = 3'd4
    } status_t;

    typedef struct packed {
        logic                  mode;
        logic [BYTE_WIDTH-1:0] data_byte;
        logic                  last_byte;
        logic [CP_WIDTH-1:0]   read_index;
    } in_item_t;

    typedef struct packed {
        status_t                       status;
        logic [RESULT_COUNT_WIDTH-1:0] count;
    } out_item_t;

endpackage

// ===== src/utf8_codepoint_histogram_unit.sv =====
// ============================================================================
// utf8_codepoint_histogram_unit
// decodes utf-8 text bytes and keeps a saturating count per code point
// ============================================================================
//
//  port group | direction | transaction carries
//  -----------+-----------+--------------------------------------------------
//  s_*        | in        | mode, data_byte, last_byte, read_index
//  m_*        | out       | status, count (one result per input transaction)
//
//  one transaction per cycle sustained while m_ready stays high; a result
//  passes the decode (in the accept cycle), the update stage register
//  (histogram read-modify-write) and then the result register
//  the histogram memory has one write and one read port; a read that meets a
//  write to the same entry in the same cycle takes the written value
//  after reset a clearing pass writes zero to all MAX_CODE_POINT + 1 entries,
//  one per cycle; s_ready stays low until the clearing pass is done
//  a stalled m_ready holds the result register and the update stage; the
//  input keeps flowing until both are full
//
module utf8_codepoint_histogram_unit #(
    parameter int MAX_CODE_POINT = u8hist_pkg::MAX_CODE_POINT_DEF,
    parameter int COUNT_WIDTH    = u8hist_pkg::COUNT_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  u8hist_pkg::in_item_t  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output u8hist_pkg::out_item_t m_data
);

    localparam int DEPTH  = MAX_CODE_POINT + 1;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_CODE_POINT);
    localparam logic [u8hist_pkg::CP_WIDTH-1:0] MAX_CP =
        u8hist_pkg::CP_WIDTH'(MAX_CODE_POINT);

    // ------------------------------------------------------------------
    // histogram store
    // ------------------------------------------------------------------
    logic [COUNT_WIDTH-1:0] hist_mem [DEPTH];
    logic [COUNT_WIDTH-1:0] mem_rdata_reg;

    logic                   wr_en;
    logic [ADDR_W-1:0]      wr_addr;
    logic [COUNT_WIDTH-1:0] wr_data;
    logic                   rd_en;
    logic [ADDR_W-1:0]      rd_addr;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            hist_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            mem_rdata_reg <= hist_mem[rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // clearing pass after reset
    // ------------------------------------------------------------------
    logic              clear_done_reg, clear_done_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;

    always_comb begin
        clear_done_next = clear_done_reg;
        clr_addr_next   = clr_addr_reg;
        if (!clear_done_reg) begin
            if (clr_addr_reg == LAST_ADDR) begin
                clear_done_next = 1'b1;
            end else begin
                clr_addr_next = clr_addr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_done_reg <= 1'b0;
            clr_addr_reg   <= '0;
        end else begin
            clear_done_reg <= clear_done_next;
            clr_addr_reg   <= clr_addr_next;
        end
    end

    // ------------------------------------------------------------------
    // handshake
    // ------------------------------------------------------------------
    logic st1_valid_reg, st1_valid_next;
    logic m_valid_reg, m_valid_next;
    logic out_free;
    logic st1_adv;
    logic s_fire;

    // result register free this cycle, or emptied by the taker
    assign out_free = !m_valid_reg || m_ready;
    assign st1_adv  = st1_valid_reg && out_free;
    assign s_ready  = clear_done_reg && (!st1_valid_reg || out_free);
    assign s_fire   = s_valid && s_ready;

    // ------------------------------------------------------------------
    // decode stage: line state lives in flops, updated at a byte-mode accept
    // ------------------------------------------------------------------
    logic [u8hist_pkg::PEND_WIDTH-1:0] pend_reg, pend_next;
    logic [u8hist_pkg::CP_WIDTH-1:0]   cp_reg, cp_next;
    logic                              failed_reg, failed_next;

    logic [u8hist_pkg::PEND_WIDTH-1:0] pend_new;
    logic [u8hist_pkg::CP_WIDTH-1:0]   cp_new;
    logic                              dec_err;
    logic                              dec_inc;
    logic                              idx_in_range;
    u8hist_pkg::status_t               dec_status;

    always_comb begin
        dec_err  = 1'b0;
        pend_new = pend_reg;
        cp_new   = cp_reg;

        // byte classes
        case (s_data.data_byte) inside
            [8'h00:8'h7F]: begin
                dec_err = (pend_reg != u8hist_pkg::PEND_NONE);
                cp_new  = u8hist_pkg::CP_WIDTH'(s_data.data_byte);
            end
            [8'h80:8'hBF]: begin
                dec_err  = (pend_reg == u8hist_pkg::PEND_NONE);
                cp_new   = {cp_reg[u8hist_pkg::CP_WIDTH-u8hist_pkg::CONT_BITS-1:0],
                            s_data.data_byte[u8hist_pkg::CONT_BITS-1:0]};
                pend_new = pend_reg - 1'b1;
            end
            [8'hC0:8'hDF]: begin
                dec_err  = (pend_reg != u8hist_pkg::PEND_NONE);
                cp_new   = u8hist_pkg::CP_WIDTH'(s_data.data_byte & u8hist_pkg::LEAD2_MASK);
                pend_new = u8hist_pkg::PEND_LEAD2;
            end
            [8'hE0:8'hEF]: begin
                dec_err  = (pend_reg != u8hist_pkg::PEND_NONE);
                cp_new   = u8hist_pkg::CP_WIDTH'(s_data.data_byte & u8hist_pkg::LEAD3_MASK);
                pend_new = u8hist_pkg::PEND_LEAD3;
            end
            [8'hF0:8'hF7]: begin
                dec_err  = (pend_reg != u8hist_pkg::PEND_NONE);
                cp_new   = u8hist_pkg::CP_WIDTH'(s_data.data_byte & u8hist_pkg::LEAD4_MASK);
                pend_new = u8hist_pkg::PEND_LEAD4;
            end
            default: begin
                // 0xf8 and above never start a sequence
                dec_err = 1'b1;
            end
        endcase

        // partial code point beyond the store range
        if (cp_new > MAX_CP) begin
            dec_err = 1'b1;
        end

        pend_next   = pend_reg;
        cp_next     = cp_reg;
        failed_next = failed_reg;
        dec_inc     = 1'b0;
        dec_status  = u8hist_pkg::ST_ACCEPTED;

        if (s_data.mode == u8hist_pkg::MODE_READ) begin
            dec_status = u8hist_pkg::ST_READ_DONE;
        end else if (failed_reg) begin
            // line already bad: drop bytes until its end
            if (s_data.last_byte) begin
                pend_next   = u8hist_pkg::PEND_NONE;
                cp_next     = '0;
                failed_next = 1'b0;
                dec_status  = u8hist_pkg::ST_LINE_INVALID;
            end else begin
                dec_status  = u8hist_pkg::ST_DISCARDED;
            end
        end else begin
            // complete code point counts even on the final byte
            dec_inc = !dec_err && (pend_new == u8hist_pkg::PEND_NONE);
            if (s_data.last_byte) begin
                pend_next   = u8hist_pkg::PEND_NONE;
                cp_next     = '0;
                failed_next = 1'b0;
                dec_status  = (dec_err || pend_new != u8hist_pkg::PEND_NONE) ?
                              u8hist_pkg::ST_LINE_INVALID : u8hist_pkg::ST_LINE_VALID;
            end else if (dec_err) begin
                failed_next = 1'b1;
                dec_status  = u8hist_pkg::ST_LINE_INVALID;
            end else begin
                pend_next   = pend_new;
                cp_next     = cp_new;
            end
        end
    end

    assign idx_in_range = (s_data.read_index <= MAX_CP);

    // memory read issued at accept: count address or lookup address
    assign rd_en = s_fire;
    always_comb begin
        rd_addr = '0;
        if (s_data.mode == u8hist_pkg::MODE_READ) begin
            if (idx_in_range) begin
                rd_addr = s_data.read_index[ADDR_W-1:0];
            end
        end else if (dec_inc) begin
            rd_addr = cp_new[ADDR_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg   <= u8hist_pkg::PEND_NONE;
            cp_reg     <= '0;
            failed_reg <= 1'b0;
        end else if (s_fire && s_data.mode == u8hist_pkg::MODE_BYTE) begin
            pend_reg   <= pend_next;
            cp_reg     <= cp_next;
            failed_reg <= failed_next;
        end
    end

    // ------------------------------------------------------------------
    // update stage: read-modify-write with same-entry forwarding
    // ------------------------------------------------------------------
    u8hist_pkg::status_t    st1_status_reg;
    logic                   st1_inc_reg;
    logic                   st1_in_range_reg;
    logic [ADDR_W-1:0]      st1_addr_reg;
    logic                   fwd_hit_reg;
    logic [COUNT_WIDTH-1:0] fwd_data_reg;

    logic [COUNT_WIDTH-1:0]                    cur_count;
    logic [COUNT_WIDTH-1:0]                    inc_count;
    logic [63:0]                               cur_wide;
    logic [u8hist_pkg::RESULT_COUNT_WIDTH-1:0] res_count;

    // entry written this cycle and read in the same cycle: memory gives stale data
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            st1_status_reg   <= dec_status;
            st1_inc_reg      <= (s_data.mode == u8hist_pkg::MODE_BYTE) && dec_inc;
            st1_in_range_reg <= idx_in_range;
            st1_addr_reg     <= rd_addr;
            fwd_hit_reg      <= wr_en && (wr_addr == rd_addr);
            fwd_data_reg     <= wr_data;
        end
    end

    assign cur_count = fwd_hit_reg ? fwd_data_reg : mem_rdata_reg;
    // saturating increment
    assign inc_count = (&cur_count) ? cur_count : cur_count + 1'b1;
    assign cur_wide  = 64'(cur_count);

    always_comb begin
        res_count = '0;
        if (st1_status_reg == u8hist_pkg::ST_READ_DONE && st1_in_range_reg) begin
            // wide counters clip to the result width
            res_count = (|cur_wide[63:u8hist_pkg::RESULT_COUNT_WIDTH]) ? '1 :
                        cur_wide[u8hist_pkg::RESULT_COUNT_WIDTH-1:0];
        end
    end

    // write port: clearing pass first, then count updates
    always_comb begin
        if (!clear_done_reg) begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_reg;
            wr_data = '0;
        end else begin
            wr_en   = st1_adv && st1_inc_reg;
            wr_addr = st1_addr_reg;
            wr_data = inc_count;
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    u8hist_pkg::out_item_t out_reg;

    always_comb begin
        st1_valid_next = st1_valid_reg;
        if (s_fire) begin
            st1_valid_next = 1'b1;
        end else if (st1_adv) begin
            st1_valid_next = 1'b0;
        end

        m_valid_next = m_valid_reg;
        if (st1_adv) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            st1_valid_reg <= st1_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (st1_adv) begin
            out_reg.status <= st1_status_reg;
            out_reg.count  <= res_count;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

// ===== src/u8hist_checker.sv =====
// ============================================================================
// u8hist_checker
// port-level checks of the utf-8 code point histogram unit
// ============================================================================
module u8hist_checker (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input u8hist_pkg::out_item_t m_data
);

    // a stalled result stays put
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // reset empties the pipe and blocks input until the store is cleared
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !s_ready && !m_valid)
        else $error("ready or valid high after reset");

    // only a read transaction carries a count
    a_count_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != u8hist_pkg::ST_READ_DONE |-> m_data.count == '0)
        else $error("nonzero count on a byte result");

    // a result that appears on an empty output came from an accept that went through the update stage
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
        else $error("result without matching input transaction");

endmodule

bind utf8_codepoint_histogram_unit u8hist_checker u_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
